/* rtl/tlg_pkg.sv */
package tlg_pkg;

  localparam int ROW_W = 16;
  localparam int CNT_W = 5;
  localparam int MAX_GRID_DEFAULT = 16;

  localparam logic [CNT_W-1:0] GRID_RESET = 5'd10;
  localparam logic [CNT_W-1:0] MIN_GRID = 5'd3;

  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] KEEP_COUNT = 4'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef logic [ROW_W-1:0] row_t;

  typedef enum logic {
    ST_IDLE,
    ST_STEP
  } state_t;

endpackage

/* rtl/tlg_ram.sv */
module tlg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds its value until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/tlg_rule.sv */
module tlg_rule
  import tlg_pkg::*;
(
  input  row_t             above,
  input  row_t             mid,
  input  row_t             below,
  input  logic [CNT_W-1:0] n,
  input  row_t             mask,
  output row_t             row
);

  logic [3:0] li [ROW_W];
  logic [3:0] ri [ROW_W];
  logic [3:0] cnt [ROW_W];
  row_t       fresh;

  // Each column is independent; the wrap columns depend on the live grid size.
  always_comb begin
    for (int c = 0; c < ROW_W; c++) begin
      li[c] = (c == 0) ? 4'(n - 5'd1) : 4'(c - 1);
      ri[c] = (5'(c) == n - 5'd1) ? 4'd0 : 4'(c + 1);
      cnt[c] = {3'b0, above[li[c]]} + {3'b0, above[c]} + {3'b0, above[ri[c]]}
             + {3'b0, mid[li[c]]} + {3'b0, mid[ri[c]]}
             + {3'b0, below[li[c]]} + {3'b0, below[c]} + {3'b0, below[ri[c]]};
      fresh[c] = (cnt[c] == BIRTH_COUNT) || ((cnt[c] == KEEP_COUNT) && mid[c]);
    end
  end

  assign row = fresh & mask;

endmodule

/* rtl/toroidal_life_generation_step.sv */
// Toroidal Game of Life (B3/S23) on a grid of up to 16 by 16 cells.
// Input channel (in_valid/in_ready): operation 0 loads row_bits into row
// row_index if below n, with no result; operation 1 advances one generation.
// Output channel (out_valid/out_ready): after a step, one transfer per row,
// rows 0 to n-1 in order, last_row set on row n-1.
// cfg_we/cfg_wdata write grid_size (n, held within 3 and the row limit).
// Loads can be accepted back to back. A step streams the rows through the
// single read port of the row memory, one row per cycle while the receiver
// keeps up, and the block takes its next item only after the last row of
// the step has been emitted.
// If the receiver stalls, the output register holds the row and the read
// stream pauses; nothing is lost.
// Reset (rst, synchronous) marks every row as dead through per-row valid
// bits, so no clearing pass is needed, and sets grid_size to 10.
module toroidal_life_generation_step
  import tlg_pkg::*;
#(
  parameter int MAX_GRID = MAX_GRID_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             operation,
  input  logic [3:0]       row_index,
  input  logic [15:0]      row_bits,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [3:0]       out_row_index,
  output logic [15:0]      out_row_bits,
  output logic             last_row
);

  localparam int ROWS = (MAX_GRID < ROW_W) ? MAX_GRID : ROW_W;
  localparam int AW = $clog2(ROWS);
  localparam logic [CNT_W-1:0] NMAX = CNT_W'(ROWS);

  state_t state, state_next;

  logic [CNT_W-1:0] grid_size;
  logic [CNT_W-1:0] n;
  row_t             mask;
  logic [ROWS-1:0]  row_valid;

  logic [CNT_W-1:0] rk;
  logic [CNT_W-1:0] sc;
  logic [3:0]       crow;
  logic             rv;
  logic             rd_ok;
  logic             wv;
  row_t             above, mid, below, wrap_first;

  logic             in_xfer, load_go, step_go;
  logic             re, shift, emit, feed_from_reg, feed_avail, last_emit;
  logic [CNT_W-1:0] raddr_full;
  logic [AW-1:0]    raddr, waddr;
  logic             we;
  row_t             wdata, rdata, feed, rule_row;

  // Live grid size and column mask.
  always_comb begin
    if (grid_size < MIN_GRID) begin
      n = MIN_GRID;
    end else if (grid_size > NMAX) begin
      n = NMAX;
    end else begin
      n = grid_size;
    end
    mask = ROW_W'((32'd1 << n) - 32'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= GRID_RESET;
    end else if (cfg_we) begin
      grid_size <= cfg_wdata;
    end
  end

  assign in_xfer = in_valid && in_ready;
  assign load_go = in_xfer && (operation == OP_LOAD) && ({1'b0, row_index} < n);
  assign step_go = in_xfer && (operation == OP_STEP);

  // Feed order of a step: old row n-1, old rows 0 to n-1 from memory, then
  // old row 0 again from a register, since by then it has been rewritten.
  assign feed_from_reg = (sc == n + 5'd1);
  assign feed_avail = feed_from_reg || rv;
  assign emit = wv && (!out_valid || out_ready);
  assign shift = (state == ST_STEP) && (sc <= n + 5'd1) && feed_avail && (!wv || emit);
  assign re = (state == ST_STEP) && (rk <= n) && (!rv || (shift && !feed_from_reg));
  assign raddr_full = (rk == 5'd0) ? n - 5'd1 : rk - 5'd1;
  assign raddr = raddr_full[AW-1:0];
  assign feed = feed_from_reg ? wrap_first : ((rd_ok ? rdata : '0) & mask);
  assign last_emit = emit && (crow == 4'(n - 5'd1));

  // Row i is written only after old row i+1 has been fetched, and later
  // fetches go to rows above i+1, so no forwarding is needed.
  assign we = load_go || emit;
  assign waddr = emit ? crow[AW-1:0] : row_index[AW-1:0];
  assign wdata = emit ? rule_row : (row_bits & mask);

  tlg_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS),
    .ADDR_W(AW)
  ) u_rows (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  tlg_rule u_rule (
    .above(above),
    .mid  (mid),
    .below(below),
    .n    (n),
    .mask (mask),
    .row  (rule_row)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (step_go) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (last_emit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_STEP: in_ready = 1'b0;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_valid <= '0;
      rk        <= '0;
      sc        <= '0;
      crow      <= '0;
      rv        <= 1'b0;
      wv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (we) begin
        row_valid[waddr] <= 1'b1;
      end
      if (step_go) begin
        rk   <= '0;
        sc   <= '0;
        crow <= '0;
        rv   <= 1'b0;
        wv   <= 1'b0;
      end else begin
        if (re) begin
          rk <= rk + 5'd1;
        end
        if (re) begin
          rv <= 1'b1;
        end else if (shift && !feed_from_reg) begin
          rv <= 1'b0;
        end
        if (shift) begin
          sc <= sc + 5'd1;
          wv <= (sc >= 5'd2);
        end else if (emit) begin
          wv <= 1'b0;
        end
        if (emit) begin
          crow <= crow + 4'd1;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_ok <= row_valid[raddr];
    end
    if (shift) begin
      above <= mid;
      mid   <= below;
      below <= feed;
      if (sc == 5'd1) begin
        wrap_first <= feed;
      end
    end
    if (emit) begin
      out_row_index <= crow;
      out_row_bits  <= rule_row;
      last_row      <= (crow == 4'(n - 5'd1));
    end
  end

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!rv && !wv))
    else $error("row pipeline holds data while idle");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (re && emit) |-> (raddr != crow[AW-1:0]))
    else $error("row write collides with a fetch of the same row");

  a_feed_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP) |-> (sc <= n + 5'd2))
    else $error("feed count ran past the grid");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    last_emit |=> (state == ST_IDLE) && out_valid && last_row)
    else $error("last row did not end the step");

endmodule
